[hdl/cbst_pkg.sv]
// Package for the complete BST level-order builder.
// Sizes, derived widths and the sequencer state type. No dependencies.
package cbst_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_BITS = 16;

  // Width of the key port and the result key port.
  localparam int KEY_PORT_W = 16;
  // Bits of a key that are kept and stored.
  localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DESC,
    ST_RD,
    ST_WR,
    ST_UP,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } state_t;

endpackage

[hdl/complete_bst_level_order_builder.sv]
// Top level of the complete BST level-order (Eytzinger) builder.
// Depends on cbst_pkg and cbst_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, key, is_final) takes one key per
//   transaction. in_ready is high only while the block is idle. Each key is
//   placed by insertion sort in the key RAM: each stored key that is greater
//   than it is read, compared and shifted up one slot, and the key is then
//   written into the slot left free. A key arriving with MAX_KEYS keys stored
//   is dropped and flags the batch. After the final key, an in-order walk
//   over the implicit tree copies the sorted keys into a level RAM (one tree
//   step per cycle), then the results leave on the output channel
//   (out_valid/out_ready, out_key, end_of_run, dropped) one at a time, one
//   per stored key, in level order; each result is taken before the next
//   is read. end_of_run marks the last one; the count and overflow flag
//   then clear for the next batch. A stalled result waits in the output
//   register; the block holds until it is taken. Reset returns to idle with
//   an empty batch; RAM contents are not cleared and need not be.
module complete_bst_level_order_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cbst_pkg::KEY_PORT_W-1:0] key,
  input  logic                            is_final,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cbst_pkg::KEY_PORT_W-1:0] out_key,
  output logic                            end_of_run,
  output logic                            dropped
);

  import cbst_pkg::*;

  localparam int NW = CNT_W + 1;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              overflow, overflow_next;
  logic [KEY_W-1:0]  k, k_next;
  logic              fin, fin_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  i, i_next;
  logic [CNT_W-1:0]  j, j_next;
  logic [CNT_W-1:0]  node, node_next;
  logic                  out_valid_next;
  logic [KEY_PORT_W-1:0] out_key_next;
  logic                  end_of_run_next;
  logic                  dropped_next;

  logic              srt_we;
  logic [ADDR_W-1:0] srt_waddr, srt_raddr;
  logic [KEY_W-1:0]  srt_wdata, srt_rdata;
  logic              lvl_we;
  logic [ADDR_W-1:0] lvl_waddr, lvl_raddr;
  logic [KEY_W-1:0]  lvl_rdata;

  logic [CNT_W-1:0]  pos_m1, node_m1, i_inc, j_inc;
  logic [NW-1:0]     node2, node2p1, n_ext;

  assign pos_m1  = pos - CNT_W'(1);
  assign node_m1 = node - CNT_W'(1);
  assign i_inc   = i + CNT_W'(1);
  assign j_inc   = j + CNT_W'(1);
  assign node2   = {node, 1'b0};
  assign node2p1 = {node, 1'b1};
  assign n_ext   = {1'b0, count};

  cbst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_sorted (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  cbst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_level (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (srt_rdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      overflow  <= overflow_next;
      out_valid <= out_valid_next;
    end
    k          <= k_next;
    fin        <= fin_next;
    pos        <= pos_next;
    i          <= i_next;
    j          <= j_next;
    node       <= node_next;
    out_key    <= out_key_next;
    end_of_run <= end_of_run_next;
    dropped    <= dropped_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    overflow_next   = overflow;
    k_next          = k;
    fin_next        = fin;
    pos_next        = pos;
    i_next          = i;
    j_next          = j;
    node_next       = node;
    out_valid_next  = out_valid;
    out_key_next    = out_key;
    end_of_run_next = end_of_run;
    dropped_next    = dropped;
    in_ready        = (state == ST_IDLE);
    srt_we          = 1'b0;
    srt_waddr       = pos[ADDR_W-1:0];
    srt_wdata       = k;
    srt_raddr       = pos_m1[ADDR_W-1:0];
    lvl_we          = 1'b0;
    lvl_waddr       = node_m1[ADDR_W-1:0];
    lvl_raddr       = j[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          k_next   = key[KEY_W-1:0];
          fin_next = is_final;
          if (count == CNT_W'(MAX_KEYS)) begin
            overflow_next = 1'b1;
            if (is_final) begin
              node_next  = CNT_W'(1);
              i_next     = '0;
              state_next = ST_DESC;
            end
          end else begin
            pos_next   = count;
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (pos == '0) begin
          srt_we     = 1'b1;
          count_next = count + CNT_W'(1);
          node_next  = CNT_W'(1);
          i_next     = '0;
          state_next = fin ? ST_DESC : ST_IDLE;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        srt_we = 1'b1;
        if (srt_rdata > k) begin
          // shift the larger key up one slot
          srt_wdata  = srt_rdata;
          pos_next   = pos_m1;
          state_next = ST_INS_RD;
        end else begin
          count_next = count + CNT_W'(1);
          node_next  = CNT_W'(1);
          i_next     = '0;
          state_next = fin ? ST_DESC : ST_IDLE;
        end
      end
      ST_DESC: begin
        if (node2 <= n_ext) begin
          node_next = node2[CNT_W-1:0];
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        srt_raddr  = i[ADDR_W-1:0];
        state_next = ST_WR;
      end
      ST_WR: begin
        lvl_we = 1'b1;
        i_next = i_inc;
        if (i_inc == count) begin
          j_next     = '0;
          state_next = ST_EM_RD;
        end else if (node2p1 <= n_ext) begin
          node_next  = node2p1[CNT_W-1:0];
          state_next = ST_DESC;
        end else begin
          state_next = ST_UP;
        end
      end
      ST_UP: begin
        node_next = node >> 1;
        if (!node[0]) begin
          state_next = ST_RD;
        end
      end
      ST_EM_RD: begin
        state_next = ST_EM_LD;
      end
      ST_EM_LD: begin
        out_valid_next  = 1'b1;
        out_key_next    = KEY_PORT_W'(lvl_rdata);
        end_of_run_next = (j_inc == count);
        dropped_next    = overflow;
        state_next      = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (end_of_run) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = ST_IDLE;
          end else begin
            j_next     = j_inc;
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && end_of_run) |=> (count == '0 && !overflow && in_ready))
    else $error("batch state not cleared after last result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count <= CNT_W'(MAX_KEYS)))
    else $error("stored count beyond capacity");

  a_level_addr: assert property (@(posedge clk) disable iff (rst)
    lvl_we |-> (node != '0 && node <= count))
    else $error("level write outside the tree");

endmodule

[hdl/cbst_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cbst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
